@@ hw/rtl/u8v_pkg.sv @@
// u8v_pkg: shared types, constants and helpers for the UTF-8 payload validator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package u8v_pkg;

    localparam int unsigned MAX_BYTES = 32;

    localparam int unsigned CNT_W = 6;
    localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(MAX_BYTES + 1);
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_BYTES);
    localparam logic [CNT_W-1:0] POS_CLAMP = '1;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR = 21'h010000;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_CONT,
        KIND_BAD
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_LONG = 3'd1,
        ST_ZERO     = 3'd2,
        ST_BAD_LEAD = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_BAD_CONT = 3'd5,
        ST_BAD_CP   = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       message_done;
        logic [2:0] status;
    } out_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [5:0] bits;
        logic       is_zero;
        logic       last;
    } cls_item_t;

    typedef struct packed {
        logic      avail;
        cls_item_t item;
    } q_head_t;

    function automatic logic [CP_W-1:0] class_min(input logic [1:0] cls);
        logic [CP_W-1:0] m;
        case (cls)
            2'd1:    m = MIN_TWO;
            2'd2:    m = MIN_THREE;
            default: m = MIN_FOUR;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/u8v_front.sv @@
// u8v_front: input handshake and byte classification.
// Depends on u8v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8v_front (
    input  wire logic               push,
    input  wire u8v_pkg::in_item_t  in_item,
    input  wire logic               q_full,
    output logic                    full,
    output logic                    enq,
    output u8v_pkg::cls_item_t      enq_item
);

    logic [7:0] b;

    assign b    = in_item.data_byte;
    assign full = q_full;
    assign enq  = push && !q_full;

    always_comb
    begin
        enq_item.is_zero = (b == 8'h00);
        enq_item.last    = in_item.last_byte;
        enq_item.bits    = b[5:0];
        case (b) inside
            [8'h00:8'h7F]:
            begin
                enq_item.kind = u8v_pkg::KIND_ASCII;
            end
            [8'h80:8'hBF]:
            begin
                enq_item.kind = u8v_pkg::KIND_CONT;
            end
            [8'hC0:8'hDF]:
            begin
                enq_item.kind = u8v_pkg::KIND_LEAD2;
                enq_item.bits = {1'b0, b[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                enq_item.kind = u8v_pkg::KIND_LEAD3;
                enq_item.bits = {2'b0, b[3:0]};
            end
            [8'hF0:8'hF7]:
            begin
                enq_item.kind = u8v_pkg::KIND_LEAD4;
                enq_item.bits = {3'b0, b[2:0]};
            end
            default:
            begin
                enq_item.kind = u8v_pkg::KIND_BAD;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/u8v_queue.sv @@
// u8v_queue: short queue of classified bytes between front and back.
// Depends on u8v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8v_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                enq,
    input  wire u8v_pkg::cls_item_t  enq_item,
    output logic                     full,
    input  wire logic                deq,
    output u8v_pkg::q_head_t         head
);

    u8v_pkg::cls_item_t                 mem_reg [u8v_pkg::Q_DEPTH];
    logic [u8v_pkg::Q_PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [u8v_pkg::Q_PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [u8v_pkg::Q_CNT_W-1:0]        cnt_reg, cnt_next;

    localparam logic [u8v_pkg::Q_PTR_W-1:0] PTR_LAST = u8v_pkg::Q_PTR_W'(u8v_pkg::Q_DEPTH - 1);
    localparam logic [u8v_pkg::Q_CNT_W-1:0] CNT_FULL = u8v_pkg::Q_CNT_W'(u8v_pkg::Q_DEPTH);

    assign full       = (cnt_reg == CNT_FULL);
    assign head.avail = (cnt_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_reg[wr_ptr_reg] <= enq_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/u8v_back.sv @@
// u8v_back: sequence decoder, length and zero checks, verdict and result register.
// Depends on u8v_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8v_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire u8v_pkg::q_head_t   head,
    output logic                    deq,
    output logic                    empty,
    input  wire logic               pop,
    output u8v_pkg::out_item_t      out_item
);

    localparam int unsigned CW = u8v_pkg::CNT_W;
    localparam int unsigned PW = u8v_pkg::CP_W;

    logic [1:0]          left_reg, left_next;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [1:0]          mincls_reg, mincls_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       seq_end_reg, seq_end_next;
    logic                zero_seen_reg, zero_seen_next;
    u8v_pkg::status_t    first_err_reg, first_err_next;
    logic [CW-1:0]       err_end_reg, err_end_next;
    logic                out_valid_reg, out_valid_next;
    u8v_pkg::out_item_t  out_reg, out_next;

    u8v_pkg::cls_item_t  it;
    logic [1:0]          lead_left;
    logic [1:0]          lead_cls;
    logic [CW:0]         end_sum;
    logic [PW-1:0]       acc_shift;
    u8v_pkg::status_t    verdict;

    assign it       = head.item;
    assign deq      = head.avail && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;
    assign end_sum  = {1'b0, count_reg} + (CW+1)'(lead_left) + (CW+1)'(1);
    assign acc_shift = {acc_reg[PW-7:0], it.bits};

    always_comb
    begin
        case (it.kind)
            u8v_pkg::KIND_LEAD2:
            begin
                lead_left = 2'd1;
                lead_cls  = 2'd1;
            end
            u8v_pkg::KIND_LEAD3:
            begin
                lead_left = 2'd2;
                lead_cls  = 2'd2;
            end
            default:
            begin
                lead_left = 2'd3;
                lead_cls  = 2'd3;
            end
        endcase
    end

    always_comb
    begin
        left_next      = left_reg;
        acc_next       = acc_reg;
        mincls_next    = mincls_reg;
        count_next     = count_reg;
        seq_end_next   = seq_end_reg;
        zero_seen_next = zero_seen_reg;
        first_err_next = first_err_reg;
        err_end_next   = err_end_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        verdict        = u8v_pkg::ST_OK;

        if (deq)
        begin
            if (count_reg < u8v_pkg::COUNT_SAT)
            begin
                count_next = count_reg + 1'b1;
            end
            if (it.is_zero)
            begin
                zero_seen_next = 1'b1;
            end

            if (first_err_reg == u8v_pkg::ST_OK)
            begin
                if (left_reg == 2'd0)
                begin
                    case (it.kind)
                        u8v_pkg::KIND_ASCII:
                        begin
                        end
                        u8v_pkg::KIND_LEAD2, u8v_pkg::KIND_LEAD3, u8v_pkg::KIND_LEAD4:
                        begin
                            left_next    = lead_left;
                            acc_next     = PW'(it.bits);
                            mincls_next  = lead_cls;
                            seq_end_next = (end_sum > (CW+1)'(u8v_pkg::POS_CLAMP))
                                         ? u8v_pkg::POS_CLAMP : end_sum[CW-1:0];
                        end
                        default:
                        begin
                            first_err_next = u8v_pkg::ST_BAD_LEAD;
                        end
                    endcase
                end
                else if (it.kind != u8v_pkg::KIND_CONT)
                begin
                    first_err_next = u8v_pkg::ST_BAD_CONT;
                    err_end_next   = seq_end_reg;
                end
                else
                begin
                    acc_next  = acc_shift;
                    left_next = left_reg - 1'b1;
                    if (left_reg == 2'd1)
                    begin
                        if (acc_shift < u8v_pkg::class_min(mincls_reg)
                            || acc_shift > u8v_pkg::CP_MAX
                            || (acc_shift >= u8v_pkg::SURR_LO && acc_shift <= u8v_pkg::SURR_HI))
                        begin
                            first_err_next = u8v_pkg::ST_BAD_CP;
                        end
                    end
                end
            end

            if (it.last)
            begin
                if (count_next > u8v_pkg::COUNT_LIMIT)
                begin
                    verdict = u8v_pkg::ST_TOO_LONG;
                end
                else if (zero_seen_next)
                begin
                    verdict = u8v_pkg::ST_ZERO;
                end
                else if (first_err_next == u8v_pkg::ST_BAD_CONT && err_end_next > count_next)
                begin
                    verdict = u8v_pkg::ST_TRUNC;
                end
                else if (first_err_next != u8v_pkg::ST_OK)
                begin
                    verdict = first_err_next;
                end
                else if (left_next != 2'd0)
                begin
                    verdict = u8v_pkg::ST_TRUNC;
                end

                left_next      = '0;
                acc_next       = '0;
                mincls_next    = '0;
                count_next     = '0;
                seq_end_next   = '0;
                zero_seen_next = 1'b0;
                first_err_next = u8v_pkg::ST_OK;
                err_end_next   = '0;
            end

            out_valid_next        = 1'b1;
            out_next.message_done = it.last;
            out_next.status       = verdict;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            acc_reg       <= '0;
            mincls_reg    <= '0;
            count_reg     <= '0;
            seq_end_reg   <= '0;
            zero_seen_reg <= 1'b0;
            first_err_reg <= u8v_pkg::ST_OK;
            err_end_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            acc_reg       <= acc_next;
            mincls_reg    <= mincls_next;
            count_reg     <= count_next;
            seq_end_reg   <= seq_end_next;
            zero_seen_reg <= zero_seen_next;
            first_err_reg <= first_err_next;
            err_end_reg   <= err_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/utf8_payload_validator_unit.sv @@
// utf8_payload_validator_unit: top level of the UTF-8 payload validator.
// Depends on u8v_pkg, u8v_front, u8v_queue and u8v_back.
//
//   channel   handshake        payload      transaction
//   input     push / full      in_item      one payload byte, last flag
//   result    empty / pop      out_item     one result per byte, verdict on last
//
// One byte per cycle sustained while pop keeps up; a byte's result is shown after it
// passes the queue register and then the result register, when the queue is empty.
// The front classifies bytes into a four-entry queue; the back decodes one
// queued byte per cycle while pop keeps up, into a single result register,
// refilled in the cycle it is popped. Reset clears the queue, the decoder state
// and the result. A stalled result side fills the queue, then full rises.
`timescale 1ns / 1ps
`default_nettype none

module utf8_payload_validator_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire u8v_pkg::in_item_t  in_item,
    output logic                    empty,
    input  wire logic               pop,
    output u8v_pkg::out_item_t      out_item
);

    logic                q_full;
    logic                enq;
    u8v_pkg::cls_item_t  enq_item;
    logic                deq;
    u8v_pkg::q_head_t    head;

    u8v_front u_front (
        .push     (push),
        .in_item  (in_item),
        .q_full   (q_full),
        .full     (full),
        .enq      (enq),
        .enq_item (enq_item)
    );

    u8v_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_item (enq_item),
        .full     (q_full),
        .deq      (deq),
        .head     (head)
    );

    u8v_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .deq      (deq),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

@@ hw/rtl/u8v_checker.sv @@
// u8v_checker: port-level assertions for the UTF-8 payload validator.
// Depends on u8v_pkg; bound to utf8_payload_validator_unit.
`timescale 1ns / 1ps
`default_nettype none

module u8v_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire u8v_pkg::in_item_t  in_item,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire u8v_pkg::out_item_t out_item
);

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> out_item.status != 3'd7)
        else $error("status code out of range");

    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.message_done) |-> out_item.status == u8v_pkg::ST_OK)
        else $error("verdict on a transaction that is not the last byte");

    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push) && !$past(full))
        else $error("full rose without an accepted transaction");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty && $stable(out_item))
        else $error("waiting result changed or vanished");

endmodule

bind utf8_payload_validator_unit u8v_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

`default_nettype wire
